// File: sv/zzdvb_pkg.sv
package zzdvb_pkg;

  // Capacity of one block in values; the key store holds one bit per value.
  localparam int unsigned MaxValues = 4096;
  localparam int unsigned KeyDepth  = (MaxValues + 7) / 8;
  localparam int unsigned KeyAw     = $clog2(KeyDepth);

  // Field widths.
  localparam int unsigned CountW  = 13;
  localparam int unsigned ValueW  = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned BytePosW = 14;
  localparam int unsigned KeyLenW = CountW - 3;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_VALUE_COUNT = 1'b0,
    CFG_SEED_VALUE  = 1'b1
  } cfg_reg_e;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 32;

  // Zigzag decode: even codes map to non-negative deltas, odd codes to negative ones.
  function automatic logic [ValueW-1:0] unzigzag(input logic [ValueW-1:0] code);
    logic [ValueW-1:0] sign_mask;
    sign_mask = {ValueW{code[0]}};
    return (code >> 1) ^ sign_mask;
  endfunction

endpackage

// File: sv/zigzag_delta_varbyte16_decoder.sv
// A result enters the output register in the cycle after the transfer of the
// byte that completes its code; key bytes and low halves of two-byte codes give none.
// Throughput: one byte per cycle while the output is not stalled; the running prefix
// updates combinationally; the registered key read is prefetched for the next value.
// Reset (rst_ni low, asynchronous) clears positions, prefix, held byte state, the
// registers and the output valid; the key store has no reset and needs no clearing pass.
module zigzag_delta_varbyte16_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  // Configuration write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [zzdvb_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [zzdvb_pkg::CfgDataW-1:0]    cfg_data_i,

  // Byte input stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [zzdvb_pkg::InDataW-1:0]     s_axis_tdata,  // [7:0] stream_byte
  input  logic [0:0]                        s_axis_tuser,  // [0] block_start

  // Decoded value stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [zzdvb_pkg::OutDataW-1:0]    m_axis_tdata,  // [15:0] decoded_value,
                                                           // [29:16] bytes_consumed,
                                                           // [31:30] zero
  output logic                              m_axis_tlast   // last_value
);

  import zzdvb_pkg::*;

  localparam int unsigned VpW = CountW;

  // Configuration registers.
  logic [CountW-1:0]   value_count_q;
  logic [ValueW-1:0]   seed_value_q;

  // Decoder state.
  logic [BytePosW-1:0] byte_pos_q, byte_pos_d;
  logic [VpW-1:0]      value_pos_q, value_pos_d;
  logic [ValueW-1:0]   prefix_q, prefix_d;
  logic [ByteW-1:0]    held_q, held_d;
  logic                await_hi_q, await_hi_d;

  // Key store with a registered read port and a bypass for a write that
  // lands on the address being read in the same cycle.
  logic [ByteW-1:0]    key_mem [KeyDepth];
  logic [ByteW-1:0]    key_rd_q;
  logic                byp_hit_q;
  logic [ByteW-1:0]    byp_data_q;
  logic                key_we;
  logic [KeyAw-1:0]    key_waddr;
  logic [KeyAw-1:0]    key_raddr;
  logic [ByteW-1:0]    key_byte;

  // Output register.
  logic                out_valid_q, out_valid_d;
  logic [ValueW-1:0]   out_value_q, out_value_d;
  logic [BytePosW-1:0] out_bytes_q, out_bytes_d;
  logic                out_last_q, out_last_d;

  // Per-byte working signals.
  logic                in_xfer;
  logic                start;
  logic [ByteW-1:0]    in_byte;
  logic [BytePosW-1:0] byte_pos_cur;
  logic [VpW-1:0]      value_pos_cur;
  logic [ValueW-1:0]   prefix_cur;
  logic                await_hi_cur;
  logic [CountW-1:0]   n_eff;
  logic [BytePosW-1:0] key_len;
  logic                active;
  logic                key_phase;
  logic                key_bit;
  logic [ValueW-1:0]   code;
  logic [ValueW-1:0]   sum;
  logic                emit;

  assign cfg_ready_o = 1'b1;

  // The byte input only stalls while a finished result is still waiting.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign start         = s_axis_tuser[0];
  assign in_byte       = s_axis_tdata[ByteW-1:0];

  // The key byte for the current value was read on the previous cycle.
  assign key_byte = byp_hit_q ? byp_data_q : key_rd_q;

  always_comb begin
    // A block start clears the positions and reloads the prefix before the byte is used.
    byte_pos_cur  = start ? '0 : byte_pos_q;
    value_pos_cur = start ? '0 : value_pos_q;
    await_hi_cur  = start ? 1'b0 : await_hi_q;
    prefix_cur    = start ? seed_value_q : prefix_q;

    // Counts beyond the capacity are clamped; the key section is one byte per eight values.
    n_eff     = (value_count_q > CountW'(MaxValues)) ? CountW'(MaxValues) : value_count_q;
    key_len   = BytePosW'((KeyLenW + 1)'((n_eff + CountW'(7)) >> 3));
    active    = value_pos_cur < n_eff;
    key_phase = byte_pos_cur < key_len;
    key_bit   = key_byte[value_pos_cur[2:0]];

    // Two-byte codes are little-endian: the held byte is the low half.
    code = key_bit ? {in_byte, held_q} : {{(ValueW - ByteW){1'b0}}, in_byte};
    sum  = unzigzag(code) + prefix_cur;

    byte_pos_d  = byte_pos_q;
    value_pos_d = value_pos_q;
    prefix_d    = prefix_q;
    held_d      = held_q;
    await_hi_d  = await_hi_q;
    key_we      = 1'b0;
    emit        = 1'b0;

    if (in_xfer) begin
      byte_pos_d  = byte_pos_cur;
      value_pos_d = value_pos_cur;
      prefix_d    = prefix_cur;
      await_hi_d  = await_hi_cur;
      if (active) begin
        byte_pos_d = byte_pos_cur + BytePosW'(1);
        if (key_phase) begin
          key_we = 1'b1;
        end else if (key_bit && !await_hi_cur) begin
          // Low half of a two-byte code: hold it until the high half arrives.
          held_d     = in_byte;
          await_hi_d = 1'b1;
        end else begin
          emit        = 1'b1;
          prefix_d    = sum;
          value_pos_d = value_pos_cur + VpW'(1);
          await_hi_d  = 1'b0;
        end
      end
    end
  end

  assign key_waddr = byte_pos_cur[KeyAw-1:0];
  assign key_raddr = value_pos_d[KeyAw+2:3];

  always_comb begin
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    out_bytes_d = out_bytes_q;
    out_last_d  = out_last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_value_d = sum;
      out_bytes_d = byte_pos_d;
      out_last_d  = (value_pos_d == n_eff);
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_waddr] <= in_byte;
    end
    key_rd_q   <= key_mem[key_raddr];
    byp_data_q <= in_byte;
    out_value_q <= out_value_d;
    out_bytes_q <= out_bytes_d;
    out_last_q  <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_count_q <= '0;
      seed_value_q  <= '0;
      byte_pos_q    <= '0;
      value_pos_q   <= '0;
      prefix_q      <= '0;
      held_q        <= '0;
      await_hi_q    <= 1'b0;
      byp_hit_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_VALUE_COUNT: value_count_q <= cfg_data_i[CountW-1:0];
          CFG_SEED_VALUE:  seed_value_q  <= cfg_data_i[ValueW-1:0];
          default: ;
        endcase
      end
      byte_pos_q  <= byte_pos_d;
      value_pos_q <= value_pos_d;
      prefix_q    <= prefix_d;
      held_q      <= held_d;
      await_hi_q  <= await_hi_d;
      byp_hit_q   <= key_we && (key_waddr == key_raddr);
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - ValueW - BytePosW){1'b0}}, out_bytes_q, out_value_q};
  assign m_axis_tlast  = out_last_q;

endmodule

// File: sv/zzdvb_checker.sv
module zzdvb_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [zzdvb_pkg::OutDataW-1:0]    m_axis_tdata,
  input logic                              m_axis_tlast
);

  import zzdvb_pkg::*;

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // A new result only appears after a byte transfer.
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("result without a byte transfer");

  // The input must stall while a result waits to be taken.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while output stalled");

  // Every result follows at least one key byte and one data byte, and padding is zero.
  a_bytes_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[ValueW+BytePosW-1:ValueW] > BytePosW'(1)) &&
      (m_axis_tdata[OutDataW-1:ValueW+BytePosW] == '0))
    else $error("bad byte count or padding");

endmodule

bind zigzag_delta_varbyte16_decoder zzdvb_checker u_zzdvb_checker (.*);

// File: verif/zigzag_delta_varbyte16_decoder_tb.sv
`timescale 1ns / 100ps

module zigzag_delta_varbyte16_decoder_tb;
  import zzdvb_pkg::*;

  // The run ends with a failure if it has not finished after this many cycles.
  localparam int unsigned CycleLimit = 400000;
  // A result is registered in the cycle after its last byte; the bench then waits
  // SettleCycles of quiet after the last expected value before touching registers.
  localparam int unsigned SettleCycles = 4;
  // Number of meaningful random bytes before the capacity block.
  localparam int unsigned RandomBytes = 700;
  // Data bytes sent after the full key section of the capacity block.
  localparam int unsigned CapDataBytes = 40;

  // One byte of the compressed stream together with its block start flag.
  typedef struct {
    logic [ByteW-1:0] data;
    logic             start;
  } stream_byte_t;

  // One decoded value as it should leave the block.
  typedef struct {
    logic [ValueW-1:0]   value;
    logic                last;
    logic [BytePosW-1:0] consumed;
  } decoded_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [0:0]          s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  zigzag_delta_varbyte16_decoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Bytes waiting to be offered and decoded values waiting to be seen.
  stream_byte_t pending_bytes[$];
  decoded_t     expected_values[$];
  int unsigned  bytes_queued   = 0;
  int unsigned  bytes_accepted = 0;
  int unsigned  mismatches     = 0;
  int unsigned  cycle_count    = 0;

  // Percentages of cycles in which the sender holds back or the receiver stalls.
  int unsigned  send_gap_pct   = 28;
  int unsigned  recv_stall_pct = 60;

  // Shadow of the decoder: registers, key bytes of the current block, and the
  // running position and prefix.
  logic [CountW-1:0] cfg_count = '0;
  logic [ValueW-1:0] cfg_seed  = '0;
  logic [ByteW-1:0]  key_mem [KeyDepth];
  int unsigned       pos_byte  = 0;
  int unsigned       pos_value = 0;
  logic [ValueW-1:0] prefix    = '0;
  logic [ByteW-1:0]  low_half  = '0;
  logic              wait_high = 1'b0;

  // Advances the shadow by one accepted byte and queues the value it completes.
  // Key bytes, ignored bytes and low halves of two-byte codes queue nothing.
  function automatic void decode_byte(input logic [ByteW-1:0] b, input logic start);
    int unsigned       n;
    int unsigned       key_len;
    logic [ValueW-1:0] code;
    logic [ValueW-1:0] delta;
    logic              wide;
    decoded_t          res;
    if (start) begin
      pos_byte  = 0;
      pos_value = 0;
      wait_high = 1'b0;
      prefix    = cfg_seed;
    end
    // Counts above capacity are clipped, and the clip is applied on every byte.
    n = (cfg_count < MaxValues) ? cfg_count : MaxValues;
    if (pos_value >= n) return;
    key_len = (n + 7) / 8;
    if (pos_byte < key_len) begin
      key_mem[KeyAw'(pos_byte)] = b;
      pos_byte++;
      return;
    end
    pos_byte++;
    wide = key_mem[KeyAw'(pos_value / 8)][3'(pos_value % 8)];
    if (!wide) begin
      code = {8'h00, b};
    end else if (!wait_high) begin
      low_half  = b;
      wait_high = 1'b1;
      return;
    end else begin
      code      = {b, low_half};
      wait_high = 1'b0;
    end
    // Zigzag: the low bit carries the sign, the rest the magnitude.
    delta     = (code >> 1) ^ {ValueW{code[0]}};
    prefix    = prefix + delta;
    pos_value++;
    res.value    = prefix;
    res.last     = (pos_value == n);
    res.consumed = BytePosW'(pos_byte);
    expected_values.push_back(res);
  endfunction

  // Byte driver. A byte stays on the bus until its transfer; the next one is
  // offered right after the transfer or after a random gap.
  always @(posedge clk_i) begin
    stream_byte_t item;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_byte(s_axis_tdata[ByteW-1:0], s_axis_tuser[0]);
        bytes_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_bytes.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          item = pending_bytes.pop_front();
          s_axis_tdata  <= item.data;
          s_axis_tuser  <= item.start;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Every transfer on the output side is compared with the
  // oldest expected value; ready is redrawn each cycle.
  always @(posedge clk_i) begin
    decoded_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_values.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected output transfer: value %h last %b bytes %0d",
                     m_axis_tdata[15:0], m_axis_tlast, m_axis_tdata[29:16]);
        end else begin
          want = expected_values.pop_front();
          if (m_axis_tdata[15:0] !== want.value || m_axis_tlast !== want.last ||
              m_axis_tdata[29:16] !== want.consumed || m_axis_tdata[31:30] !== 2'b00) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: want %h/%b/%0d got %h/%b/%0d pad %b",
                       want.value, want.last, want.consumed, m_axis_tdata[15:0],
                       m_axis_tlast, m_axis_tdata[29:16], m_axis_tdata[31:30]);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic push_byte(input logic [ByteW-1:0] b, input logic start);
    stream_byte_t item;
    item.data  = b;
    item.start = start;
    pending_bytes.push_back(item);
    bytes_queued++;
  endtask

  // Writes one register and updates the shadow at the transfer.
  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_VALUE_COUNT) cfg_count = data[CountW-1:0];
    else cfg_seed = data;
  endtask

  // Waits until every queued byte has been transferred and every expected
  // value has come out, then lets the pipeline settle.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (!(bytes_accepted == bytes_queued && expected_values.size() == 0));
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Queues one block of n values: key bytes, then a code per value whose width
  // follows its key bit. A truncated block stops at a random byte. Trailing
  // bytes go out without a block start and are ignored once the block is done.
  task automatic push_block(input int unsigned n, input bit truncate,
                            input int unsigned trailing, input bit all_wide,
                            output int unsigned sent);
    logic [ByteW-1:0] body[$];
    int unsigned      key_len;
    int unsigned      key_style;
    int unsigned      i;
    key_len   = (n + 7) / 8;
    key_style = all_wide ? 1 : $urandom_range(3);
    for (i = 0; i < key_len; i++)
      body.push_back(key_style == 0 ? 8'h00 : key_style == 1 ? 8'hFF : 8'($urandom));
    for (i = 0; i < n; i++) begin
      body.push_back(8'($urandom));
      if (body[i / 8][3'(i % 8)]) body.push_back(8'($urandom));
    end
    if (body.size() == 0) body.push_back(8'($urandom));
    sent = (truncate && body.size() > 1) ? $urandom_range(body.size() - 1, 1) : body.size();
    for (i = 0; i < sent; i++) push_byte(body[i], i == 0);
    for (i = 0; i < trailing; i++) push_byte(8'($urandom), 1'b0);
  endtask

  initial begin
    int unsigned       items_made;
    int unsigned       sent;
    int unsigned       r;
    int unsigned       nblocks;
    int unsigned       blk;
    logic [CountW-1:0] count;
    logic [ValueW-1:0] seed;
    items_made = 0;
    for (int i = 0; i < KeyDepth; i++) key_mem[KeyAw'(i)] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Bytes before any block start decode from the reset state with a zero
    // prefix. One narrow code, one wide code, one narrow, then an ignored byte.
    write_reg(CFG_VALUE_COUNT, 16'd3);
    push_byte(8'h02, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h55, 1'b0);
    wait_drained();

    // Largest seed with two wide codes that wrap the prefix, a stray byte after
    // the end, then a restart in the middle of a wide code.
    write_reg(CFG_SEED_VALUE, 16'hFFFF);
    write_reg(CFG_VALUE_COUNT, 16'd2);
    push_byte(8'h03, 1'b1);
    push_byte(8'hFE, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(8'h01, 1'b1);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    wait_drained();

    // A zero count ignores every byte, block start or not.
    write_reg(CFG_VALUE_COUNT, 16'd0);
    write_reg(CFG_SEED_VALUE, 16'h0000);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b1);
    wait_drained();

    // Random phases: each picks a count and a seed, then sends a few blocks,
    // mostly complete, some cut short, some followed by ignored bytes.
    while (items_made < RandomBytes) begin
      if (items_made >= 2 * RandomBytes / 3) begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end else if (items_made >= RandomBytes / 3) begin
        send_gap_pct   = 60;
        recv_stall_pct = 28;
      end
      r = $urandom_range(99);
      count = CountW'((r < 10) ? 0 : (r < 70) ? $urandom_range(24, 1) :
              (r < 90) ? $urandom_range(120, 25) : $urandom_range(9, 1));
      r = $urandom_range(99);
      seed = (r < 15) ? 16'h0000 : (r < 30) ? 16'hFFFF : 16'($urandom);
      if ($urandom_range(1)) begin
        write_reg(CFG_VALUE_COUNT, {3'($urandom), count});
        write_reg(CFG_SEED_VALUE, seed);
      end else begin
        write_reg(CFG_SEED_VALUE, seed);
        write_reg(CFG_VALUE_COUNT, {3'($urandom), count});
      end
      nblocks = $urandom_range(4, 1);
      for (blk = 0; blk < nblocks; blk++) begin
        r = $urandom_range(99);
        push_block(count, r >= 80, (r < 60) ? 0 : $urandom_range(3, 1), 1'b0, sent);
        if (count != 0) items_made += sent;
      end
      wait_drained();
    end

    // Full capacity: the largest count clips to the maximum, so the key section
    // fills the whole key store; a run of wide codes follows and the block is
    // cut short.
    write_reg(CFG_VALUE_COUNT, 16'hFFFF);
    write_reg(CFG_SEED_VALUE, 16'($urandom));
    for (int i = 0; i < KeyDepth; i++) push_byte(8'hFF, i == 0);
    for (int i = 0; i < CapDataBytes; i++) push_byte(8'($urandom), 1'b0);
    wait_drained();

    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
